FILE: hdl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Types and constants shared by the sensor compensation blocks.
// ----------------------------------------------------------------------------
package stc_pkg;

   typedef enum logic [2:0] {
      CSR_TEMP    = 3'd0,
      CSR_PRESS_A = 3'd1,
      CSR_PRESS_B = 3'd2,
      CSR_PRESS_C = 3'd3,
      CSR_HUM_A   = 3'd4,
      CSR_HUM_B   = 3'd5
   } csr_index_type;

   localparam int ARITH_STAGES = 12;
   localparam int DIV_STAGES   = 64;
   localparam int FIN_STAGES   = 5;

   localparam logic [20:0]        P_FULL_SCALE = 21'd1048576;
   localparam logic signed [32:0] P_TFINE_OFS  = 33'sd128000;
   localparam logic [63:0]        P_BIAS       = 64'd1 << 47;
   localparam logic [12:0]        P_SCALE      = 13'd3125;
   localparam logic signed [31:0] T_ROUND      = 32'sd128;
   localparam logic signed [31:0] H_TFINE_OFS  = 32'sd76800;
   localparam logic signed [31:0] H_ROUND_A    = 32'sd16384;
   localparam logic signed [31:0] H_OFS_B      = 32'sd32768;
   localparam logic signed [31:0] H_OFS_C      = 32'sd2097152;
   localparam logic signed [31:0] H_ROUND_C    = 32'sd8192;
   localparam logic signed [31:0] H_MAX        = 32'sd419430400;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
      logic [15:0] raw_humidity;
   } req_item_type;

   typedef struct packed {
      logic [47:0] temp_coeffs;
      logic [47:0] press_coeffs_a;
      logic [47:0] press_coeffs_b;
      logic [47:0] press_coeffs_c;
      logic [31:0] hum_coeffs_a;
      logic [39:0] hum_coeffs_b;
   } coef_type;

   typedef struct packed {
      logic [31:0] temperature;
      logic [20:0] press_ofs;
      logic [15:0] hum_raw;
      logic [63:0] num_mag;
      logic [30:0] den_mag;
      logic        quot_neg;
      logic        div_zero;
   } arith_carry_type;

   typedef struct packed {
      logic [31:0] temperature;
      logic [16:0] humidity;
      logic        div_zero;
      logic        quot_neg;
   } carry_type;

   typedef struct packed {
      carry_type   info;
      logic [30:0] divisor;
      logic [30:0] rem;
      logic [63:0] quot;
   } div_stage_type;

endpackage

FILE: hdl/stc_if.sv
// ----------------------------------------------------------------------------
// stc channel interfaces
// Raw reading, compensated result and register write channels.
// ----------------------------------------------------------------------------
interface stc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_pressure;
   logic [19:0] raw_temperature;
   logic [15:0] raw_humidity;
   modport source (output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
   modport sink (input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface

interface stc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] temperature_centi;
   logic [31:0] pressure_q24_8;
   logic [16:0] humidity_q22_10;
   logic        pressure_div_zero;
   modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                   pressure_div_zero, input ready);
   modport sink (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                 pressure_div_zero, output ready);
endinterface

interface stc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/stc_front.sv
// ----------------------------------------------------------------------------
// stc_front
// Coefficient registers and a two-entry queue of accepted readings.
// ----------------------------------------------------------------------------
module stc_front
   import stc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   stc_req_if.sink       req_chan,
   stc_csr_if.sink       csr_chan,
   input  logic          pop,
   output logic          head_valid,
   output req_item_type  head,
   output coef_type      coef
);

   coef_type     coef_ff, coef_in;
   req_item_type slot_ff [2];
   req_item_type item;
   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic         push;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_TEMP:    coef_in.temp_coeffs    = csr_chan.data;
            CSR_PRESS_A: coef_in.press_coeffs_a = csr_chan.data;
            CSR_PRESS_B: coef_in.press_coeffs_b = csr_chan.data;
            CSR_PRESS_C: coef_in.press_coeffs_c = csr_chan.data;
            CSR_HUM_A:   coef_in.hum_coeffs_a   = csr_chan.data[31:0];
            CSR_HUM_B:   coef_in.hum_coeffs_b   = csr_chan.data[39:0];
            default:     coef_in = coef_ff;
         endcase
      end
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid & req_chan.ready;
   assign item           = '{raw_pressure: req_chan.raw_pressure,
                             raw_temperature: req_chan.raw_temperature,
                             raw_humidity: req_chan.raw_humidity};
   assign count_in       = 2'(count_ff + {1'b0, push} - {1'b0, pop});
   assign wr_ptr_in      = wr_ptr_ff ^ push;
   assign rd_ptr_in      = rd_ptr_ff ^ pop;
   assign head_valid     = (count_ff != 2'd0);
   assign head           = slot_ff[rd_ptr_ff];
   assign coef           = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         coef_ff   <= coef_in;
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

FILE: hdl/stc_arith.sv
// ----------------------------------------------------------------------------
// stc_arith
// Temperature, humidity and pressure operand pipeline ahead of the divider.
// ----------------------------------------------------------------------------
module stc_arith
   import stc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  coef_type      coef,
   input  logic          head_valid,
   input  req_item_type  head,
   output logic          pop,
   output logic          out_valid,
   output div_stage_type out_stage
);

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, h2, h4, h5;
   logic [7:0]         h1, h3;
   logic signed [7:0]  h6;

   logic [ARITH_STAGES-1:0] vld_ff, vld_in;
   arith_carry_type         cy_ff [ARITH_STAGES];
   arith_carry_type         cy_in [ARITH_STAGES];

   // stage a
   logic signed [17:0] ta;
   logic signed [16:0] td;
   logic signed [33:0] ta_prod, td_prod;
   logic signed [31:0] a_v1p_ff, a_v1p_in, a_dd_ff, a_dd_in;
   // stage b
   logic signed [31:0] b_dd;
   logic signed [47:0] b_prod;
   logic signed [31:0] b_v1_ff, b_v1_in, b_v2p_ff, b_v2p_in;
   // stage c
   logic signed [31:0] c_v2;
   logic signed [31:0] c_tf_ff, c_tf_in;
   // stage d
   logic signed [31:0] d_tsum;
   logic signed [31:0] d_temp;
   logic signed [32:0] d_pv_ff, d_pv_in;
   logic signed [31:0] d_hx_ff, d_hx_in;
   // stage e
   logic signed [65:0] e_sq;
   logic signed [48:0] e_v5_ff, e_v5_in, e_v2p_ff, e_v2p_in;
   logic signed [63:0] e_vv_ff, e_vv_in;
   logic signed [47:0] e_m5;
   logic signed [39:0] e_m6;
   logic signed [40:0] e_m3;
   logic signed [31:0] e_h5x_ff, e_h5x_in, e_h6x_ff, e_h6x_in, e_h3x_ff, e_h3x_in;
   // stage f
   logic signed [79:0] f_m6, f_m3;
   logic signed [63:0] f_vv6_ff, f_vv6_in, f_vv3_ff, f_vv3_in;
   logic [63:0]        f_v2a_ff, f_v2a_in, f_v1b_ff, f_v1b_in;
   logic signed [31:0] f_ha0, f_ha1;
   logic signed [31:0] f_ha_ff, f_ha_in, f_hb1_ff, f_hb1_in, f_hb2_ff, f_hb2_in;
   logic signed [31:0] f_h3s;
   // stage g
   logic signed [63:0] g_vv3s;
   logic [63:0]        g_v2_ff, g_v2_in, g_v1_ff, g_v1_in;
   logic signed [63:0] g_m;
   logic signed [31:0] g_hb_ff, g_hb_in, g_ha_ff, g_ha_in;
   // stage h
   logic signed [80:0] h_m1;
   logic [63:0]        h_den_ff, h_den_in, h_n0_ff, h_n0_in;
   logic signed [31:0] h_hbs, h_hb0;
   logic signed [47:0] h_m2;
   logic signed [31:0] h_hb_ff, h_hb_in, h_ha_ff, h_ha_in;
   // stage i
   logic [76:0]        i_m;
   logic [63:0]        i_num_ff, i_num_in;
   logic [30:0]        i_den_ff, i_den_in;
   logic signed [31:0] i_hb0;
   logic signed [63:0] i_m2;
   logic signed [31:0] i_hx_ff, i_hx_in;
   // stage j
   logic signed [31:0] j_d;
   logic signed [63:0] j_m;
   logic signed [31:0] j_hdd_ff, j_hdd_in, j_hx_ff, j_hx_in;
   // stage k
   logic signed [31:0] k_d7;
   logic signed [40:0] k_m;
   logic signed [31:0] k_t_ff, k_t_in, k_hx_ff, k_hx_in;
   // stage l
   logic signed [31:0] l_t4, l_x, l_xc;
   logic [16:0]        l_hum_ff, l_hum_in;

   assign t1 = coef.temp_coeffs[15:0];
   assign t2 = $signed(coef.temp_coeffs[31:16]);
   assign t3 = $signed(coef.temp_coeffs[47:32]);
   assign p1 = coef.press_coeffs_a[15:0];
   assign p2 = $signed(coef.press_coeffs_a[31:16]);
   assign p3 = $signed(coef.press_coeffs_a[47:32]);
   assign p4 = $signed(coef.press_coeffs_b[15:0]);
   assign p5 = $signed(coef.press_coeffs_b[31:16]);
   assign p6 = $signed(coef.press_coeffs_b[47:32]);
   assign h1 = coef.hum_coeffs_a[7:0];
   assign h2 = $signed(coef.hum_coeffs_a[23:8]);
   assign h3 = coef.hum_coeffs_a[31:24];
   assign h4 = $signed(coef.hum_coeffs_b[15:0]);
   assign h5 = $signed(coef.hum_coeffs_b[31:16]);
   assign h6 = $signed(coef.hum_coeffs_b[39:32]);

   assign pop       = en & head_valid;
   assign vld_in    = {vld_ff[ARITH_STAGES-2:0], head_valid};
   assign out_valid = vld_ff[ARITH_STAGES-1];

   always_comb begin
      // temperature
      ta       = $signed({1'b0, head.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
      td       = $signed({1'b0, head.raw_temperature[19:4]}) - $signed({1'b0, t1});
      ta_prod  = ta * t2;
      td_prod  = td * td;
      a_v1p_in = ta_prod[31:0];
      a_dd_in  = td_prod[31:0];

      b_v1_in  = a_v1p_ff >>> 11;
      b_dd     = a_dd_ff >>> 12;
      b_prod   = b_dd * t3;
      b_v2p_in = b_prod[31:0];

      c_v2     = b_v2p_ff >>> 14;
      c_tf_in  = b_v1_ff + c_v2;

      d_tsum   = (c_tf_ff <<< 2) + c_tf_ff + T_ROUND;
      d_temp   = d_tsum >>> 8;
      d_pv_in  = {c_tf_ff[31], c_tf_ff} - P_TFINE_OFS;
      d_hx_in  = c_tf_ff - H_TFINE_OFS;

      // pressure operands and humidity terms
      e_sq     = d_pv_ff * d_pv_ff;
      e_vv_in  = e_sq[63:0];
      e_v5_in  = d_pv_ff * p5;
      e_v2p_in = d_pv_ff * p2;
      e_m5     = h5 * d_hx_ff;
      e_h5x_in = e_m5[31:0];
      e_m6     = d_hx_ff * h6;
      e_h6x_in = e_m6[31:0];
      e_m3     = d_hx_ff * $signed({1'b0, h3});
      e_h3x_in = e_m3[31:0];

      f_m6     = e_vv_ff * p6;
      f_vv6_in = f_m6[63:0];
      f_m3     = e_vv_ff * p3;
      f_vv3_in = f_m3[63:0];
      f_v2a_in = ({{15{e_v5_ff[48]}}, e_v5_ff} << 17) + ({{48{p4[15]}}, p4} << 35);
      f_v1b_in = {{15{e_v2p_ff[48]}}, e_v2p_ff} << 12;
      f_ha0    = $signed({2'b00, cy_ff[4].hum_raw, 14'd0}) - $signed({h4[11:0], 20'd0})
                 - e_h5x_ff;
      f_ha1    = f_ha0 + H_ROUND_A;
      f_ha_in  = f_ha1 >>> 15;
      f_hb1_in = e_h6x_ff >>> 10;
      f_h3s    = e_h3x_ff >>> 11;
      f_hb2_in = f_h3s + H_OFS_B;

      g_v2_in  = f_vv6_ff + f_v2a_ff;
      g_vv3s   = f_vv3_ff >>> 8;
      g_v1_in  = g_vv3s + f_v1b_ff + P_BIAS;
      g_m      = f_hb1_ff * f_hb2_ff;
      g_hb_in  = g_m[31:0];
      g_ha_in  = f_ha_ff;

      h_m1     = $signed(g_v1_ff) * $signed({1'b0, p1});
      h_den_in = h_m1[63:0];
      h_n0_in  = {12'd0, cy_ff[6].press_ofs, 31'd0} - g_v2_ff;
      h_hbs    = g_hb_ff >>> 10;
      h_hb0    = h_hbs + H_OFS_C;
      h_m2     = h_hb0 * h2;
      h_hb_in  = h_m2[31:0];
      h_ha_in  = g_ha_ff;

      i_den_in = h_den_ff[63:33];
      i_m      = h_n0_ff * P_SCALE;
      i_num_in = i_m[63:0];
      i_hb0    = (h_hb_ff + H_ROUND_C) >>> 14;
      i_m2     = h_ha_ff * i_hb0;
      i_hx_in  = i_m2[31:0];

      j_d      = i_hx_ff >>> 15;
      j_m      = j_d * j_d;
      j_hdd_in = j_m[31:0];
      j_hx_in  = i_hx_ff;

      k_d7     = j_hdd_ff >>> 7;
      k_m      = k_d7 * $signed({1'b0, h1});
      k_t_in   = k_m[31:0];
      k_hx_in  = j_hx_ff;

      l_t4     = k_t_ff >>> 4;
      l_x      = k_hx_ff - l_t4;
      if (l_x < 32'sd0) begin
         l_xc = 32'sd0;
      end else if (l_x > H_MAX) begin
         l_xc = H_MAX;
      end else begin
         l_xc = l_x;
      end
      l_hum_in = l_xc[28:12];
   end

   // per-item values that ride alongside the pipe
   always_comb begin
      cy_in[0]           = '0;
      cy_in[0].press_ofs = P_FULL_SCALE - {1'b0, head.raw_pressure};
      cy_in[0].hum_raw   = head.raw_humidity;
      for (int k = 1; k < ARITH_STAGES; k++) begin
         cy_in[k] = cy_ff[k-1];
      end
      cy_in[3].temperature = d_temp;
      cy_in[9].div_zero    = (i_den_ff == 31'd0);
      cy_in[9].quot_neg    = i_num_ff[63] ^ i_den_ff[30];
      cy_in[9].num_mag     = i_num_ff[63] ? (64'd0 - i_num_ff) : i_num_ff;
      cy_in[9].den_mag     = i_den_ff[30] ? (31'd0 - i_den_ff) : i_den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cy_ff    <= cy_in;
         a_v1p_ff <= a_v1p_in;
         a_dd_ff  <= a_dd_in;
         b_v1_ff  <= b_v1_in;
         b_v2p_ff <= b_v2p_in;
         c_tf_ff  <= c_tf_in;
         d_pv_ff  <= d_pv_in;
         d_hx_ff  <= d_hx_in;
         e_vv_ff  <= e_vv_in;
         e_v5_ff  <= e_v5_in;
         e_v2p_ff <= e_v2p_in;
         e_h5x_ff <= e_h5x_in;
         e_h6x_ff <= e_h6x_in;
         e_h3x_ff <= e_h3x_in;
         f_vv6_ff <= f_vv6_in;
         f_vv3_ff <= f_vv3_in;
         f_v2a_ff <= f_v2a_in;
         f_v1b_ff <= f_v1b_in;
         f_ha_ff  <= f_ha_in;
         f_hb1_ff <= f_hb1_in;
         f_hb2_ff <= f_hb2_in;
         g_v2_ff  <= g_v2_in;
         g_v1_ff  <= g_v1_in;
         g_hb_ff  <= g_hb_in;
         g_ha_ff  <= g_ha_in;
         h_den_ff <= h_den_in;
         h_n0_ff  <= h_n0_in;
         h_hb_ff  <= h_hb_in;
         h_ha_ff  <= h_ha_in;
         i_num_ff <= i_num_in;
         i_den_ff <= i_den_in;
         i_hx_ff  <= i_hx_in;
         j_hdd_ff <= j_hdd_in;
         j_hx_ff  <= j_hx_in;
         k_t_ff   <= k_t_in;
         k_hx_ff  <= k_hx_in;
         l_hum_ff <= l_hum_in;
      end
   end

   assign out_stage.info.temperature = cy_ff[ARITH_STAGES-1].temperature;
   assign out_stage.info.humidity    = l_hum_ff;
   assign out_stage.info.div_zero    = cy_ff[ARITH_STAGES-1].div_zero;
   assign out_stage.info.quot_neg    = cy_ff[ARITH_STAGES-1].quot_neg;
   assign out_stage.divisor          = cy_ff[ARITH_STAGES-1].den_mag;
   assign out_stage.rem              = '0;
   assign out_stage.quot             = cy_ff[ARITH_STAGES-1].num_mag;

endmodule

FILE: hdl/stc_div.sv
// ----------------------------------------------------------------------------
// stc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module stc_div
   import stc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  div_stage_type in_stage,
   output logic          out_valid,
   output div_stage_type out_stage
);

   div_stage_type stage_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      div_stage_type cur, stage_in;
      logic          cur_valid;
      logic [31:0]   trial;
      logic          ge;

      if (g == 0) begin : g_first
         assign cur       = in_stage;
         assign cur_valid = in_valid;
      end else begin : g_next
         assign cur       = stage_ff[g-1];
         assign cur_valid = vld_ff[g-1];
      end

      always_comb begin
         trial             = {cur.rem, cur.quot[63]};
         ge                = (trial >= {1'b0, cur.divisor});
         stage_in          = cur;
         stage_in.rem      = ge ? 31'(trial - {1'b0, cur.divisor}) : trial[30:0];
         stage_in.quot     = {cur.quot[62:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stage_ff[g] <= stage_in;
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_stage = stage_ff[DIV_STAGES-1];

endmodule

FILE: hdl/stc_finish.sv
// ----------------------------------------------------------------------------
// stc_finish
// Quotient sign, pressure correction terms and the result register.
// ----------------------------------------------------------------------------
module stc_finish
   import stc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  coef_type      coef,
   input  logic          in_valid,
   input  div_stage_type in_stage,
   stc_rsp_if.source     rsp_chan
);

   logic signed [15:0] p7, p8, p9;
   logic [FIN_STAGES-1:0] vld_ff, vld_in;
   carry_type cy_ff [FIN_STAGES];
   carry_type cy_in [FIN_STAGES];

   logic signed [63:0] q1_ff, q1_in;
   logic signed [63:0] s;
   logic signed [79:0] m9, m8;
   logic signed [63:0] q2_ff, q2_in, s2_ff, s2_in, a2_ff, a2_in, v2m_ff, v2m_in;
   logic [63:0]        hl_full, lh_full;
   logic [63:0]        ll3_ff, ll3_in;
   logic [31:0]        hl3_ff, hl3_in, lh3_ff, lh3_in;
   logic signed [63:0] q3_ff, q3_in, v23_ff, v23_in;
   logic signed [63:0] prod4_ff, prod4_in, q4_ff, q4_in, v24_ff, v24_in;
   logic signed [63:0] p25;
   logic [63:0]        sum;
   logic [31:0]        res;
   logic [31:0]        press_ff, press_in;

   assign p7 = $signed(coef.press_coeffs_c[15:0]);
   assign p8 = $signed(coef.press_coeffs_c[31:16]);
   assign p9 = $signed(coef.press_coeffs_c[47:32]);

   assign vld_in = {vld_ff[FIN_STAGES-2:0], in_valid};

   always_comb begin
      cy_in[0] = in_stage.info;
      for (int k = 1; k < FIN_STAGES; k++) begin
         cy_in[k] = cy_ff[k-1];
      end

      q1_in    = in_stage.info.quot_neg ? (64'sd0 - $signed(in_stage.quot))
                                         : $signed(in_stage.quot);

      s        = q1_ff >>> 13;
      m9       = s * p9;
      a2_in    = m9[63:0];
      m8       = q1_ff * p8;
      v2m_in   = m8[63:0];
      s2_in    = s;
      q2_in    = q1_ff;

      ll3_in   = a2_ff[31:0] * s2_ff[31:0];
      hl_full  = a2_ff[63:32] * s2_ff[31:0];
      lh_full  = a2_ff[31:0] * s2_ff[63:32];
      hl3_in   = hl_full[31:0];
      lh3_in   = lh_full[31:0];
      v23_in   = v2m_ff >>> 19;
      q3_in    = q2_ff;

      prod4_in = $signed(ll3_ff + {hl3_ff + lh3_ff, 32'd0});
      q4_in    = q3_ff;
      v24_in   = v23_ff;

      p25      = prod4_ff >>> 25;
      sum      = q4_ff + p25 + v24_ff;
      res      = sum[39:8] + {{12{p7[15]}}, p7, 4'd0};
      press_in = cy_ff[FIN_STAGES-2].div_zero ? 32'd0 : res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cy_ff    <= cy_in;
         q1_ff    <= q1_in;
         q2_ff    <= q2_in;
         s2_ff    <= s2_in;
         a2_ff    <= a2_in;
         v2m_ff   <= v2m_in;
         ll3_ff   <= ll3_in;
         hl3_ff   <= hl3_in;
         lh3_ff   <= lh3_in;
         q3_ff    <= q3_in;
         v23_ff   <= v23_in;
         prod4_ff <= prod4_in;
         q4_ff    <= q4_in;
         v24_ff   <= v24_in;
         press_ff <= press_in;
      end
   end

   assign rsp_chan.valid             = vld_ff[FIN_STAGES-1];
   assign rsp_chan.temperature_centi = cy_ff[FIN_STAGES-1].temperature;
   assign rsp_chan.humidity_q22_10   = cy_ff[FIN_STAGES-1].humidity;
   assign rsp_chan.pressure_div_zero = cy_ff[FIN_STAGES-1].div_zero;
   assign rsp_chan.pressure_q24_8    = press_ff;

endmodule

FILE: hdl/sensor_compensation_tph_top.sv
// ----------------------------------------------------------------------------
// sensor_compensation_tph_top
// Integer temperature, pressure and humidity compensation of raw readings.
// Pipeline: 12 operand stages, 64 divider stages at one quotient bit each and
//   5 finishing stages.
// Throughput: one reading per cycle; a two-entry input queue takes transfers
//   while the whole pipe holds for a result that is not yet taken.
// Reset: synchronous; clears the coefficient registers, queue and valid bits.
// ----------------------------------------------------------------------------
module sensor_compensation_tph_top
   import stc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   stc_req_if.sink   req_chan,
   stc_rsp_if.source rsp_chan,
   stc_csr_if.sink   csr_chan
);

   logic          adv;
   logic          pop;
   logic          head_valid;
   req_item_type  head;
   coef_type      coef;
   logic          div_in_valid, div_out_valid;
   div_stage_type div_in, div_out;

   assign adv = ~rsp_chan.valid | rsp_chan.ready;

   stc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .coef       (coef)
   );

   stc_arith u_arith (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .coef       (coef),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .out_valid  (div_in_valid),
      .out_stage  (div_in)
   );

   stc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (div_in_valid),
      .in_stage  (div_in),
      .out_valid (div_out_valid),
      .out_stage (div_out)
   );

   stc_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .coef     (coef),
      .in_valid (div_out_valid),
      .in_stage (div_out),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the temperature, pressure and humidity compensation
// block. Coefficient sets are loaded while the pipe is empty. Raw readings are
// then sent with random gaps and output stalls, none in the full-rate test.
// A bit-accurate integer model predicts each result; each field is compared.
// ----------------------------------------------------------------------------
module tb_top;
   import stc_pkg::*;

   localparam int RUN_LIMIT = 400000;

   typedef struct {
      logic [31:0] temperature;
      logic [31:0] pressure;
      logic [16:0] humidity;
      logic        div_zero;
   } compensated_type;

   logic clock;
   logic reset;
   stc_req_if req_chan ();
   stc_rsp_if rsp_chan ();
   stc_csr_if csr_chan ();

   sensor_compensation_tph_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_chan(csr_chan.sink)
   );

   logic [47:0]     coef_shadow [6];
   compensated_type pending_readings [$];
   int              fail_count;
   int              cycle_count;
   bit              idle_enable;
   int              stall_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic compensated_type compensate(input req_item_type r);
      compensated_type c;
      int t1, t2, t3, h1, h2, h3, h4, h5, h6;
      int adc_t, adc_h, v1, v2, d, tfine, a, b, x;
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint q1, q2, p, num, res, bias;
      t1 = int'({16'd0, coef_shadow[CSR_TEMP][15:0]});
      t2 = $signed(coef_shadow[CSR_TEMP][31:16]);
      t3 = $signed(coef_shadow[CSR_TEMP][47:32]);
      p1 = longint'({48'd0, coef_shadow[CSR_PRESS_A][15:0]});
      p2 = $signed(coef_shadow[CSR_PRESS_A][31:16]);
      p3 = $signed(coef_shadow[CSR_PRESS_A][47:32]);
      p4 = $signed(coef_shadow[CSR_PRESS_B][15:0]);
      p5 = $signed(coef_shadow[CSR_PRESS_B][31:16]);
      p6 = $signed(coef_shadow[CSR_PRESS_B][47:32]);
      p7 = $signed(coef_shadow[CSR_PRESS_C][15:0]);
      p8 = $signed(coef_shadow[CSR_PRESS_C][31:16]);
      p9 = $signed(coef_shadow[CSR_PRESS_C][47:32]);
      h1 = int'({24'd0, coef_shadow[CSR_HUM_A][7:0]});
      h2 = $signed(coef_shadow[CSR_HUM_A][23:8]);
      h3 = int'({24'd0, coef_shadow[CSR_HUM_A][31:24]});
      h4 = $signed(coef_shadow[CSR_HUM_B][15:0]);
      h5 = $signed(coef_shadow[CSR_HUM_B][31:16]);
      h6 = $signed(coef_shadow[CSR_HUM_B][39:32]);
      adc_t = int'({12'd0, r.raw_temperature});
      adc_h = int'({16'd0, r.raw_humidity});

      // temperature, 32-bit wrapping
      v1 = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = (adc_t >>> 4) - t1;
      v2 = (((d * d) >>> 12) * t3) >>> 14;
      tfine = v1 + v2;
      c.temperature = (tfine * 5 + 128) >>> 8;

      // pressure, 64-bit wrapping
      bias = 1;
      bias = bias <<< 47;
      q1 = longint'(tfine) - 128000;
      q2 = q1 * q1 * p6;
      q2 = q2 + ((q1 * p5) <<< 17);
      q2 = q2 + (p4 <<< 35);
      q1 = (((q1 * q1) * p3) >>> 8) + ((q1 * p2) <<< 12);
      q1 = ((bias + q1) * p1) >>> 33;
      c.pressure = '0;
      c.div_zero = 1'b0;
      if (q1 == 0) begin
         c.div_zero = 1'b1;
      end else begin
         p = 1048576 - longint'({44'd0, r.raw_pressure});
         num = ((p <<< 31) - q2) * 3125;
         if (q1 == -1) p = -num;
         else p = num / q1;
         q1 = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
         q2 = (p8 * p) >>> 19;
         res = ((p + q1 + q2) >>> 8) + (p7 <<< 4);
         c.pressure = res[31:0];
      end

      // humidity, 32-bit wrapping and clamp
      x = tfine - 76800;
      a = (adc_h <<< 14) - (h4 <<< 20) - (h5 * x);
      a = (a + 16384) >>> 15;
      b = (x * h6) >>> 10;
      b = b * (((x * h3) >>> 11) + 32768);
      b = (b >>> 10) + 2097152;
      b = ((b * h2) + 8192) >>> 14;
      x = a * b;
      d = x >>> 15;
      x = x - ((((d * d) >>> 7) * h1) >>> 4);
      if (x < 0) x = 0;
      if (x > 419430400) x = 419430400;
      x = x >>> 12;
      c.humidity = x[16:0];
      return c;
   endfunction

   // result checker
   always @(posedge clock) begin
      compensated_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result transfer", $time);
            fail_count++;
         end else begin
            e = pending_readings.pop_front();
            if (rsp_chan.temperature_centi !== e.temperature) begin
               $display("%0t: temperature exp %0d got %0d", $time,
                        $signed(e.temperature), $signed(rsp_chan.temperature_centi));
               fail_count++;
            end
            if (rsp_chan.pressure_q24_8 !== e.pressure) begin
               $display("%0t: pressure exp %h got %h", $time, e.pressure,
                        rsp_chan.pressure_q24_8);
               fail_count++;
            end
            if (rsp_chan.humidity_q22_10 !== e.humidity) begin
               $display("%0t: humidity exp %h got %h", $time, e.humidity,
                        rsp_chan.humidity_q22_10);
               fail_count++;
            end
            if (rsp_chan.pressure_div_zero !== e.div_zero) begin
               $display("%0t: div_zero exp %b got %b", $time, e.div_zero,
                        rsp_chan.pressure_div_zero);
               fail_count++;
            end
         end
      end
   end

   // output stalls
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_coef(input csr_index_type idx, input logic [47:0] value);
      logic [47:0] masked;
      masked = value;
      if (idx == CSR_HUM_A) masked[47:32] = '0;
      if (idx == CSR_HUM_B) masked[47:40] = '0;
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      coef_shadow[idx] = masked;
      csr_chan.valid <= 1'b0;
   endtask

   task automatic load_coefs(input logic [47:0] t, pa, pb, pc, ha, hb);
      write_coef(CSR_TEMP, t);
      write_coef(CSR_PRESS_A, pa);
      write_coef(CSR_PRESS_B, pb);
      write_coef(CSR_PRESS_C, pc);
      write_coef(CSR_HUM_A, ha);
      write_coef(CSR_HUM_B, hb);
   endtask

   // valid stays high across back-to-back transfers; gaps lower it
   task automatic send_reading(input logic [19:0] rp, rt, input logic [15:0] rh);
      req_item_type r;
      int gap;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.raw_pressure = rp;
      r.raw_temperature = rt;
      r.raw_humidity = rh;
      req_chan.valid           <= 1'b1;
      req_chan.raw_pressure    <= rp;
      req_chan.raw_temperature <= rt;
      req_chan.raw_humidity    <= rh;
      do @(posedge clock); while (!req_chan.ready);
      pending_readings.push_back(compensate(r));
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic load_typical;
      load_coefs({16'hFC18, 16'd26435, 16'd27504},
                 {16'd3024, 16'hD643, 16'd36477},
                 {16'hFFF9, 16'd140, 16'd2855},
                 {16'd6000, 16'hC6F8, 16'd15500},
                 {8'd0, 16'd362, 8'd75},
                 {8'd30, 16'd50, 16'd313});
   endtask

   task automatic load_jittered;
      load_coefs({16'(-1000 + $urandom_range(0, 200)), 16'(26000 + $urandom_range(0, 900)),
                  16'(27000 + $urandom_range(0, 1000))},
                 {16'(3000 + $urandom_range(0, 50)), 16'(-10700 + $urandom_range(0, 30)),
                  16'(36000 + $urandom_range(0, 1000))},
                 {16'(-7 + $urandom_range(0, 4)), 16'(100 + $urandom_range(0, 80)),
                  16'(2800 + $urandom_range(0, 100))},
                 {16'(5900 + $urandom_range(0, 200)), 16'(-14700 + $urandom_range(0, 200)),
                  16'(15400 + $urandom_range(0, 200))},
                 {8'($urandom_range(0, 255)), 16'(340 + $urandom_range(0, 40)),
                  8'(70 + $urandom_range(0, 10))},
                 {8'(25 + $urandom_range(0, 10)), 16'(40 + $urandom_range(0, 20)),
                  16'(300 + $urandom_range(0, 30))});
   endtask

   task automatic send_plausible;
      send_reading(20'($urandom_range(200000, 600000)), 20'($urandom_range(400000, 600000)),
                   16'($urandom_range(20000, 40000)));
   endtask

   task automatic send_any;
      send_reading(20'($urandom), 20'($urandom), 16'($urandom));
   endtask

   task automatic test_zero_coefs;
      send_reading('0, '0, '0);
      send_reading('1, '1, '1);
      send_reading(20'h55555, 20'hAAAAA, 16'h5555);
      drain();
   endtask

   task automatic test_directed;
      load_typical();
      send_reading('0, '0, '0);
      send_reading('1, '1, '1);
      send_reading(20'h55555, 20'hAAAAA, 16'h5555);
      send_reading(20'hAAAAA, 20'h55555, 16'hAAAA);
      send_reading(20'd415148, 20'd519888, 16'd30000);
      send_reading(20'd415148, 20'd519888, 16'd0);
      send_reading(20'd415148, 20'd519888, 16'hFFFF);
      send_reading(20'd1048575, 20'd519888, 16'd30000);
      send_reading(20'd0, 20'd519888, 16'd30000);
      drain();
      // all-ones coefficient corners, then mostly 16'h8000 fields
      load_coefs('1, '1, '1, '1, '1, '1);
      send_reading('0, '0, '0);
      send_reading('1, '1, '1);
      send_reading(20'h12345, 20'h80000, 16'h8000);
      drain();
      load_coefs({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000},
                 {8'hFF, 16'h8000, 8'hFF}, {8'h80, 16'h8000, 16'h8000});
      send_reading('0, '0, '0);
      send_reading('1, '1, '1);
      send_reading(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
      drain();
   endtask

   task automatic test_typical_random;
      for (int s = 0; s < 6; s++) begin
         load_jittered();
         for (int i = 0; i < 100; i++) begin
            if ($urandom_range(0, 9) == 0) send_any();
            else send_plausible();
         end
         drain();
      end
   endtask

   task automatic test_random_coefs;
      for (int s = 0; s < 10; s++) begin
         load_coefs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
         for (int i = 0; i < 50; i++) send_any();
         drain();
      end
   endtask

   task automatic test_extreme_coefs;
      load_coefs({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'hFFFF},
                 {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF},
                 {8'h00, 16'h7FFF, 8'h00}, {8'h7F, 16'h7FFF, 16'h7FFF});
      for (int i = 0; i < 150; i++) send_any();
      drain();
      load_coefs('0, '0, '0, '0, '0, '0);
      for (int i = 0; i < 100; i++) send_any();
      drain();
   endtask

   task automatic test_full_rate;
      idle_enable = 1'b0;
      load_typical();
      for (int i = 0; i < 250; i++) send_plausible();
      drain();
   endtask

   initial begin
      reset = 1'b1;
      fail_count = 0;
      cycle_count = 0;
      idle_enable = 1'b1;
      stall_left = 0;
      for (int i = 0; i < 6; i++) coef_shadow[i] = '0;
      req_chan.valid = 1'b0;
      req_chan.raw_pressure = '0;
      req_chan.raw_temperature = '0;
      req_chan.raw_humidity = '0;
      rsp_chan.ready = 1'b1;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_TEMP;
      csr_chan.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_zero_coefs();
      test_directed();
      test_typical_random();
      test_random_coefs();
      test_extreme_coefs();
      test_full_rate();
      drain();
      repeat (120) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
